FILE: design/irans_pkg.sv
`timescale 1ns / 1ps
// irans_pkg: shared types and constants of the interleaved rans encoder step
// no dependencies

package irans_pkg;

   localparam int unsigned STATE_W   = 32;
   localparam int unsigned FREQ_W    = 16;
   localparam int unsigned CUM_W     = 15;
   localparam int unsigned SYM_W     = 8;
   localparam int unsigned LANE_IN_W = 5;
   localparam int unsigned BITS_W    = 4;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned TBL_DEPTH = 256;
   localparam int unsigned TBL_W     = FREQ_W + CUM_W;

   localparam logic [STATE_W-1:0] STATE_LOW_BOUND = 32'd65536;
   localparam logic [BITS_W-1:0]  PROB_BITS_RESET = 4'd15;
   localparam int unsigned        EMIT_SHIFT      = 16;

   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_ENCODE  = 2'd1,
      ACT_READ    = 2'd2,
      ACT_RESTART = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_WORD  = 2'd0,
      KIND_STATE = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef struct packed {
      logic               start;
      logic [STATE_W-1:0] dividend;
      logic [FREQ_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [STATE_W-1:0] quotient;
      logic [FREQ_W-1:0]  remainder;
   } div_rsp_type;

endpackage

FILE: design/irans_if.sv
`timescale 1ns / 1ps
// irans_req_if / irans_rsp_if: valid/ready channels of the encoder step
// depends on irans_pkg

interface irans_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       action;
   logic [irans_pkg::LANE_IN_W-1:0]  lane;
   logic [irans_pkg::SYM_W-1:0]      symbol;
   logic [irans_pkg::FREQ_W-1:0]     frequency;
   logic [irans_pkg::CUM_W-1:0]      cumulative;

   modport source (output valid, action, lane, symbol, frequency, cumulative, input ready);
   modport sink   (input valid, action, lane, symbol, frequency, cumulative, output ready);
endinterface

interface irans_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [irans_pkg::KIND_W-1:0]  kind;
   logic [irans_pkg::STATE_W-1:0] value;

   modport source (output valid, kind, value, input ready);
   modport sink   (input valid, kind, value, output ready);
endinterface

FILE: design/interleaved_rans_encode_step.sv
`timescale 1ns / 1ps
// interleaved_rans_encode_step: top level, lane state ram, symbol table ram, divider
// write and restart words act at accept; readout: accept, ram read; encode: accept,
// ram read, 32 divider iterations, done, write-back; one word at a time
// the radix-2 divider sets the encode rate; a full output register stalls the read stage
// reset: synchronous; lanes read as 65536 via per-lane valid bits, prob_bits = 15,
// symbol table contents undefined until written

module interleaved_rans_encode_step #(
   parameter int unsigned LANE_COUNT = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   irans_req_if.sink                          req_ch,
   irans_rsp_if.source                        rsp_ch,
   input  logic                               csr_we,
   input  logic [irans_pkg::BITS_W-1:0]       csr_wdata
);

   localparam int unsigned LANE_W = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
   localparam int unsigned SW     = irans_pkg::STATE_W;
   localparam int unsigned FW     = irans_pkg::FREQ_W;
   localparam int unsigned CW     = irans_pkg::CUM_W;
   localparam int unsigned LIM_W  = SW + FW;

   typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_DIV, ST_WB} state_type;

   state_type                      state_ff, state_in;
   logic [irans_pkg::BITS_W-1:0]   bits_ff, bits_in;
   logic [LANE_COUNT-1:0]          valid_ff, valid_in;
   logic [1:0]                     act_ff, act_in;
   logic [LANE_W-1:0]              lane_ff, lane_in;
   logic [CW-1:0]                  cum_ff, cum_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [irans_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [SW-1:0]                  rsp_value_ff, rsp_value_in;

   logic                           accept;
   logic                           in_range;
   logic [LANE_W-1:0]              req_lane;
   logic [SW-1:0]                  lane_rdata;
   logic [irans_pkg::TBL_W-1:0]    tbl_rdata;
   logic                           lane_we;
   logic [SW-1:0]                  lane_wdata;
   logic                           tbl_we;
   logic                           lane_re;
   logic [SW-1:0]                  x_cur;
   logic [FW-1:0]                  freq_cur;
   logic [LIM_W-1:0]               limit;
   logic                           emit;
   logic                           need_out;
   logic                           slot_free;
   irans_pkg::div_req_type         div_req;
   irans_pkg::div_rsp_type         div_rsp;

   assign accept   = req_ch.valid && req_ch.ready;
   assign in_range = 32'(req_ch.lane) < LANE_COUNT;
   assign req_lane = LANE_W'(req_ch.lane);
   assign tbl_we   = accept && (req_ch.action == irans_pkg::ACT_WRITE);
   assign lane_re  = accept && in_range
                     && (req_ch.action == irans_pkg::ACT_ENCODE
                         || req_ch.action == irans_pkg::ACT_READ);

   irans_ram #(.WIDTH(SW), .DEPTH(LANE_COUNT)) u_lane_ram (
      .clock (clock),
      .we    (lane_we),
      .waddr (lane_ff),
      .wdata (lane_wdata),
      .re    (lane_re),
      .raddr (req_lane),
      .rdata (lane_rdata)
   );

   // entry layout: frequency above cumulative
   irans_ram #(.WIDTH(irans_pkg::TBL_W), .DEPTH(irans_pkg::TBL_DEPTH)) u_tbl_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (req_ch.symbol),
      .wdata ({req_ch.frequency, req_ch.cumulative}),
      .re    (lane_re),
      .raddr (req_ch.symbol),
      .rdata (tbl_rdata)
   );

   irans_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // a lane never written since reset or restart reads as the low bound
   assign x_cur     = valid_ff[lane_ff] ? lane_rdata : irans_pkg::STATE_LOW_BOUND;
   assign freq_cur  = tbl_rdata[irans_pkg::TBL_W-1:CW];
   assign limit     = LIM_W'(freq_cur) << (6'd32 - {2'b00, bits_ff});
   assign emit      = {{FW{1'b0}}, x_cur} >= limit;
   assign need_out  = (act_ff == irans_pkg::ACT_READ) || (freq_cur == '0) || emit;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   assign lane_wdata = (div_rsp.quotient << bits_ff) + SW'(cum_ff) + SW'(div_rsp.remainder);
   assign lane_we    = (state_ff == ST_WB);

   always_comb begin
      state_in     = state_ff;
      bits_in      = csr_we ? csr_wdata : bits_ff;
      valid_in     = valid_ff;
      act_in       = act_ff;
      lane_in      = lane_ff;
      cum_in       = cum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      div_req.start    = 1'b0;
      div_req.dividend = emit ? (x_cur >> irans_pkg::EMIT_SHIFT) : x_cur;
      div_req.divisor  = freq_cur;
      case (state_ff)
         ST_IDLE: begin
            if (accept && in_range) begin
               act_in  = req_ch.action;
               lane_in = req_lane;
               if (req_ch.action == irans_pkg::ACT_RESTART) begin
                  valid_in[req_lane] = 1'b0;
               end else if (req_ch.action != irans_pkg::ACT_WRITE) begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            if (!need_out || slot_free) begin
               cum_in = tbl_rdata[CW-1:0];
               if (act_ff == irans_pkg::ACT_READ) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = irans_pkg::KIND_STATE;
                  rsp_value_in = x_cur;
                  state_in     = ST_IDLE;
               end else if (freq_cur == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = irans_pkg::KIND_ERROR;
                  rsp_value_in = '0;
                  state_in     = ST_IDLE;
               end else begin
                  if (emit) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = irans_pkg::KIND_WORD;
                     rsp_value_in = {16'h0000, x_cur[15:0]};
                  end
                  div_req.start = 1'b1;
                  state_in      = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            valid_in[lane_ff] = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bits_ff      <= irans_pkg::PROB_BITS_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bits_ff      <= bits_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff       <= act_in;
      lane_ff      <= lane_in;
      cum_ff       <= cum_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.kind  = rsp_kind_ff;
   assign rsp_ch.value = rsp_value_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RD))
      else $error("result raised outside the read stage");

   a_wb_in_range: assert property (@(posedge clock) disable iff (reset)
      lane_we |-> 32'(lane_ff) < LANE_COUNT)
      else $error("lane write-back out of range");

   a_emit_then_div: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> state_ff == ST_DIV)
      else $error("divider started without entering the divide state");

endmodule

FILE: design/irans_ram.sv
`timescale 1ns / 1ps
// irans_ram: generic single-write, single-read ram with registered read data
// no dependencies

module irans_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic                                    re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/irans_div.sv
`timescale 1ns / 1ps
// irans_div: radix-2 restoring divider, 32-bit dividend by 16-bit divisor
// depends on irans_pkg

module irans_div (
   input  logic                   clock,
   input  logic                   reset,
   input  irans_pkg::div_req_type div_req,
   output irans_pkg::div_rsp_type div_rsp
);

   localparam int unsigned CNT_W = $clog2(irans_pkg::STATE_W + 1);

   logic                             run_ff, run_in;
   logic                             done_ff, done_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic [irans_pkg::STATE_W-1:0]    quo_ff, quo_in;
   logic [irans_pkg::FREQ_W-1:0]     rem_ff, rem_in;
   logic [irans_pkg::FREQ_W-1:0]     den_ff, den_in;
   logic [irans_pkg::FREQ_W:0]       shifted;
   logic [irans_pkg::FREQ_W:0]       diff;
   logic                             ge;

   assign shifted = {rem_ff, quo_ff[irans_pkg::STATE_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign ge      = shifted >= {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = div_req.dividend;
         rem_in = '0;
         den_in = div_req.divisor;
      end else if (run_ff) begin
         // one quotient bit per cycle
         rem_in = ge ? diff[irans_pkg::FREQ_W-1:0] : shifted[irans_pkg::FREQ_W-1:0];
         quo_in = {quo_ff[irans_pkg::STATE_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(irans_pkg::STATE_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

FILE: bench/irans_tb_if.sv
`timescale 1ns / 1ps
// irans_tb_pkg: expected result record used by the bench scoreboard
// depends on irans_pkg

package irans_tb_pkg;

   typedef struct packed {
      irans_pkg::kind_type           kind;
      logic [irans_pkg::STATE_W-1:0] value;
   } coder_result_type;
endpackage

FILE: bench/interleaved_rans_encode_step_test.sv
`timescale 1ns / 1ps
// interleaved_rans_encode_step_test: self-checking bench for the interleaved rans encoder step
// depends on irans_pkg, irans_tb_pkg, irans_req_if, irans_rsp_if and the top level

module interleaved_rans_encode_step_test;

   class coder_scoreboard;
      logic [irans_pkg::STATE_W-1:0] lane_x [32];
      logic [irans_pkg::FREQ_W-1:0]  freq_of [irans_pkg::TBL_DEPTH];
      logic [irans_pkg::CUM_W-1:0]   cum_of [irans_pkg::TBL_DEPTH];
      logic [irans_pkg::BITS_W-1:0]  bits;
      irans_tb_pkg::coder_result_type pending [$];
      int                            mismatches;
      int                            checked;

      function new();
         foreach (lane_x[k]) lane_x[k] = irans_pkg::STATE_LOW_BOUND;
         foreach (freq_of[k]) begin
            freq_of[k] = '0;
            cum_of[k] = '0;
         end
         bits = irans_pkg::PROB_BITS_RESET;
         mismatches = 0;
         checked = 0;
      endfunction

      function void note_word(irans_pkg::action_type act, logic [4:0] ln, logic [7:0] sym,
                              logic [15:0] fr, logic [14:0] cu);
         irans_tb_pkg::coder_result_type r;
         logic [63:0] limit;
         logic [31:0] x;
         logic [31:0] q;
         logic [31:0] m;
         case (act)
            irans_pkg::ACT_WRITE: begin
               freq_of[sym] = fr;
               cum_of[sym] = cu;
            end
            irans_pkg::ACT_READ: begin
               r.kind = irans_pkg::KIND_STATE;
               r.value = lane_x[ln];
               pending.push_back(r);
            end
            irans_pkg::ACT_RESTART: lane_x[ln] = irans_pkg::STATE_LOW_BOUND;
            default: begin
               if (freq_of[sym] == 0) begin
                  r.kind = irans_pkg::KIND_ERROR;
                  r.value = '0;
                  pending.push_back(r);
               end else begin
                  x = lane_x[ln];
                  limit = ((64'd65536 >> bits) << 16) * freq_of[sym];
                  if ({32'd0, x} >= limit) begin
                     r.kind = irans_pkg::KIND_WORD;
                     r.value = {16'd0, x[15:0]};
                     pending.push_back(r);
                     x = x >> 16;
                  end
                  q = x / freq_of[sym];
                  m = x % freq_of[sym];
                  lane_x[ln] = (q << bits) + cum_of[sym] + m;
               end
            end
         endcase
      endfunction

      function void check_word(logic [1:0] kind, logic [31:0] value);
         irans_tb_pkg::coder_result_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word kind %0d value %h", kind, value);
            return;
         end
         e = pending.pop_front();
         if (kind !== e.kind || value !== e.value) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected kind %0d value %h, got kind %0d value %h",
                        e.kind, e.value, kind, value);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [irans_pkg::BITS_W-1:0] csr_wdata;
   irans_req_if req_ch ();
   irans_rsp_if rsp_ch ();

   coder_scoreboard board;
   int  send_idle_pct;
   int  stall_pct;
   int  quiet_cycles;
   int  accepted;
   bit  written [irans_pkg::TBL_DEPTH];

   interleaved_rans_encode_step i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver side: random stall, check accepted words
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) board.check_word(rsp_ch.kind, rsp_ch.value);
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // valid stays up after an accept so the next word can follow with no gap
   task automatic send_word(irans_pkg::action_type act, logic [4:0] ln, logic [7:0] sym,
                            logic [15:0] fr, logic [14:0] cu);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.lane <= ln;
      req_ch.symbol <= sym;
      req_ch.frequency <= fr;
      req_ch.cumulative <= cu;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_word(act, ln, sym, fr, cu);
      if (act == irans_pkg::ACT_WRITE) written[sym] = 1'b1;
      accepted++;
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_bits(logic [irans_pkg::BITS_W-1:0] b);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= b;
      @(posedge clock);
      csr_we <= 1'b0;
      board.bits = b;
   endtask

   // random word; encodes only use written symbols
   task automatic random_word();
      int pick;
      logic [7:0] sym;
      logic [15:0] fr;
      pick = $urandom_range(99);
      sym = $urandom_range(255);
      if (pick < 15) begin
         fr = ($urandom_range(9) == 0) ? 16'd0 :
              ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 1 << board.bits));
         send_word(irans_pkg::ACT_WRITE, 5'($urandom), sym, fr, 15'($urandom));
      end else if (pick < 80) begin
         while (!written[sym]) sym = $urandom_range(255);
         send_word(irans_pkg::ACT_ENCODE, 5'($urandom), sym, 16'($urandom), 15'($urandom));
      end else if (pick < 95) begin
         send_word(irans_pkg::ACT_READ, 5'($urandom), sym, 16'($urandom), 15'($urandom));
      end else begin
         send_word(irans_pkg::ACT_RESTART, 5'($urandom), sym, 16'($urandom), 15'($urandom));
      end
   endtask

   initial begin
      logic [irans_pkg::BITS_W-1:0] bit_plan [6];
      board = new();
      foreach (written[k]) written[k] = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      accepted = 0;
      req_ch.valid = 1'b0;
      req_ch.action = irans_pkg::ACT_WRITE;
      req_ch.lane = '0;
      req_ch.symbol = '0;
      req_ch.frequency = '0;
      req_ch.cumulative = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: table extremes, zero frequency, renorm, readout, restart
      send_word(irans_pkg::ACT_WRITE, 5'd0, 8'd0, 16'd1, 15'd0);
      send_word(irans_pkg::ACT_WRITE, 5'd31, 8'd255, 16'd32768, 15'd32767);
      send_word(irans_pkg::ACT_WRITE, 5'd0, 8'd7, 16'd0, 15'd5);
      send_word(irans_pkg::ACT_WRITE, 5'd0, 8'd9, 16'hFFFF, 15'h7FFF);
      send_word(irans_pkg::ACT_READ, 5'd0, 8'd0, 16'd0, 15'd0);
      send_word(irans_pkg::ACT_ENCODE, 5'd0, 8'd7, 16'd0, 15'd0);
      send_word(irans_pkg::ACT_ENCODE, 5'd0, 8'd0, 16'd0, 15'd0);
      send_word(irans_pkg::ACT_ENCODE, 5'd0, 8'd0, 16'd0, 15'd0);
      send_word(irans_pkg::ACT_READ, 5'd0, 8'd0, 16'd0, 15'd0);
      send_word(irans_pkg::ACT_ENCODE, 5'd31, 8'd255, 16'd0, 15'd0);
      send_word(irans_pkg::ACT_ENCODE, 5'd31, 8'd9, 16'd0, 15'd0);
      send_word(irans_pkg::ACT_READ, 5'd31, 8'd0, 16'd0, 15'd0);
      send_word(irans_pkg::ACT_RESTART, 5'd31, 8'd0, 16'd0, 15'd0);
      send_word(irans_pkg::ACT_READ, 5'd31, 8'd0, 16'd0, 15'd0);
      for (int k = 0; k < 6; k++)
         send_word(irans_pkg::ACT_ENCODE, 5'd3, 8'd255, 16'd0, 15'd0);
      send_word(irans_pkg::ACT_READ, 5'd3, 8'd0, 16'd0, 15'd0);

      bit_plan[0] = 4'd10; bit_plan[1] = 4'd15; bit_plan[2] = 4'd12;
      bit_plan[3] = 4'd0;  bit_plan[4] = 4'd15; bit_plan[5] = 4'd11;
      for (int ph = 0; ph < 8; ph++) begin
         if (ph < 6) set_bits(bit_plan[ph]);
         else set_bits(4'($urandom));
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 77; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 77; end
            default: begin send_idle_pct = 12; stall_pct = 12; end
         endcase
         repeat (200) random_word();
      end
      send_idle_pct = 0;
      drain_results();

      $display("covered %0d input words and %0d result words over eight register settings",
               accepted, board.checked);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.pending.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

FILE: files.f
design/irans_pkg.sv
design/irans_if.sv
design/irans_ram.sv
design/irans_div.sv
design/interleaved_rans_encode_step.sv
bench/irans_tb_if.sv
bench/interleaved_rans_encode_step_test.sv
